// ===== rtl/dbd_pkg.sv =====
`default_nettype none

package dbd_pkg;

  localparam int unsigned DEPTH_DEF      = 8;
  localparam int unsigned ADDR_BYTES_DEF = 8;

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned SEQ_W    = 8;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned SRC_W    = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED  = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_DRAINED = 3'd3,
    ST_EMPTY   = 3'd4
  } dbd_status_e;

  // per-slot metadata kept next to the address
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                bcast;
    logic [SEQ_W-1:0]    seq;
    logic [LEN_W-1:0]    len;
  } dbd_meta_t;

endpackage

`default_nettype wire

// ===== rtl/dbd_mem.sv =====
`default_nettype none

module dbd_mem #(
  parameter int unsigned DEPTH  = dbd_pkg::DEPTH_DEF,
  parameter int unsigned ADDR_W = dbd_pkg::ADDR_BYTES_DEF * 8,
  parameter int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [IDX_W-1:0]  wr_idx_i,
  input  wire dbd_pkg::dbd_meta_t wr_meta_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic              rd_en_i,
  input  wire logic [IDX_W-1:0]  rd_idx_i,
  output dbd_pkg::dbd_meta_t     rd_meta_o,
  output logic      [ADDR_W-1:0] rd_addr_o
);
  import dbd_pkg::*;

  dbd_meta_t         meta_mem_q [DEPTH];
  logic [ADDR_W-1:0] addr_mem_q [DEPTH];
  dbd_meta_t         rd_meta_q;
  logic [ADDR_W-1:0] rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      meta_mem_q[wr_idx_i] <= wr_meta_i;
      addr_mem_q[wr_idx_i] <= wr_addr_i;
    end
    // read data holds until the next read
    if (rd_en_i) begin
      rd_meta_q <= meta_mem_q[rd_idx_i];
      rd_addr_q <= addr_mem_q[rd_idx_i];
    end
  end

  assign rd_meta_o = rd_meta_q;
  assign rd_addr_o = rd_addr_q;

endmodule

`default_nettype wire

// ===== rtl/dbd_ctrl.sv =====
`default_nettype none

module dbd_ctrl #(
  parameter int unsigned DEPTH      = dbd_pkg::DEPTH_DEF,
  parameter int unsigned ADDR_BYTES = dbd_pkg::ADDR_BYTES_DEF,
  parameter int unsigned ADDR_W     = ADDR_BYTES * 8,
  parameter int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         op_i,
  input  wire logic [dbd_pkg::HANDLE_W-1:0] pkt_handle_i,
  input  wire logic                         is_broadcast_i,
  input  wire logic [dbd_pkg::SEQ_W-1:0]    seq_nr_i,
  input  wire logic [dbd_pkg::LEN_W-1:0]    src_len_i,
  input  wire logic [dbd_pkg::SRC_W-1:0]    ll_addr_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [dbd_pkg::STATUS_W-1:0] status_o,
  output logic      [dbd_pkg::SLOT_W-1:0]   slot_o,
  output logic      [dbd_pkg::HANDLE_W-1:0] out_handle_o,
  output logic                              last_o,
  output logic                              wr_en_o,
  output logic      [IDX_W-1:0]             wr_idx_o,
  output dbd_pkg::dbd_meta_t                wr_meta_o,
  output logic      [ADDR_W-1:0]            wr_addr_o,
  output logic                              rd_en_o,
  output logic      [IDX_W-1:0]             rd_idx_o,
  input  wire dbd_pkg::dbd_meta_t           rd_meta_i,
  input  wire logic [ADDR_W-1:0]            rd_addr_i
);
  import dbd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT,
    S_DRAIN
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  fill_q;
  logic [CNT_W-1:0]  issue_q;
  logic              rvalid_q;
  logic [IDX_W-1:0]  ridx_q;
  logic [IDX_W-1:0]  idx_q;
  dbd_status_e       res_status_q;
  logic [IDX_W-1:0]  res_slot_q;
  dbd_meta_t         req_q;
  logic [ADDR_W-1:0] req_addr_q;

  logic              out_valid_q;
  dbd_status_e       status_q;
  logic [SLOT_W-1:0] slot_q;
  logic [HANDLE_W-1:0] handle_q;
  logic              last_q;

  logic accept;
  logic out_free;
  logic out_load;
  logic full;
  logic match;
  logic addr_eq;
  logic scan_last;
  logic drain_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = ((state_q == S_RESULT) || (state_q == S_DRAIN)) && out_free;
  assign full       = (fill_q == FULL_CNT);
  assign scan_last  = ((CNT_W'(ridx_q) + CNT_W'(1)) == fill_q);
  assign drain_last = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);

  // only the first src_len bytes take part in the address compare
  always_comb begin
    addr_eq = 1'b1;
    for (int b = 0; b < int'(ADDR_BYTES); b++) begin
      if ((LEN_W'(b) < req_q.len) && (rd_addr_i[8*b +: 8] != req_addr_q[8*b +: 8])) begin
        addr_eq = 1'b0;
      end
    end
  end

  assign match = rd_meta_i.bcast && (rd_meta_i.seq == req_q.seq) &&
                 (rd_meta_i.len == req_q.len) && addr_eq;

  always_comb begin
    rd_en_o  = 1'b0;
    rd_idx_o = '0;
    unique case (state_q)
      S_IDLE: begin
        rd_en_o = accept && (op_i == OP_DRAIN);
      end
      S_SCAN: begin
        rd_en_o  = (issue_q < fill_q);
        rd_idx_o = issue_q[IDX_W-1:0];
      end
      S_DRAIN: begin
        rd_en_o  = out_free && !drain_last;
        rd_idx_o = IDX_W'(CNT_W'(idx_q) + CNT_W'(1));
      end
      default: begin
        rd_en_o = 1'b0;
      end
    endcase
  end

  assign wr_en_o   = (state_q == S_RESULT) && out_free && (res_status_q == ST_STORED);
  assign wr_idx_o  = fill_q[IDX_W-1:0];
  assign wr_meta_o = req_q;
  assign wr_addr_o = req_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      issue_q      <= '0;
      rvalid_q     <= 1'b0;
      ridx_q       <= '0;
      idx_q        <= '0;
      res_status_q <= ST_STORED;
      res_slot_q   <= '0;
      req_q        <= '0;
      req_addr_q   <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= ST_STORED;
      slot_q       <= '0;
      handle_q     <= '0;
      last_q       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      rvalid_q <= (state_q == S_SCAN) && rd_en_o;
      ridx_q   <= rd_idx_o;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q.handle <= pkt_handle_i;
            req_q.bcast  <= is_broadcast_i;
            req_q.seq    <= seq_nr_i;
            req_q.len    <= src_len_i;
            req_addr_q   <= ll_addr_i[ADDR_W-1:0];
            issue_q      <= '0;
            idx_q        <= '0;
            if (op_i == OP_DRAIN) begin
              if (fill_q == '0) begin
                res_status_q <= ST_EMPTY;
                res_slot_q   <= '0;
                state_q      <= S_RESULT;
              end else begin
                state_q <= S_DRAIN;
              end
            end else if (is_broadcast_i && (fill_q != '0)) begin
              state_q <= S_SCAN;
            end else begin
              res_status_q <= full ? ST_FULL : ST_STORED;
              res_slot_q   <= full ? '0 : fill_q[IDX_W-1:0];
              state_q      <= S_RESULT;
            end
          end
        end
        S_SCAN: begin
          if (rd_en_o) begin
            issue_q <= issue_q + CNT_W'(1);
          end
          if (rvalid_q) begin
            if (match) begin
              res_status_q <= ST_DUP;
              res_slot_q   <= ridx_q;
              state_q      <= S_RESULT;
            end else if (scan_last) begin
              res_status_q <= full ? ST_FULL : ST_STORED;
              res_slot_q   <= full ? '0 : fill_q[IDX_W-1:0];
              state_q      <= S_RESULT;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            status_q    <= res_status_q;
            slot_q      <= SLOT_W'(res_slot_q);
            handle_q    <= (res_status_q == ST_EMPTY) ? '0 : req_q.handle;
            last_q      <= 1'b1;
            if (res_status_q == ST_STORED) begin
              fill_q <= fill_q + CNT_W'(1);
            end
            state_q <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            status_q    <= ST_DRAINED;
            slot_q      <= SLOT_W'(idx_q);
            handle_q    <= rd_meta_i.handle;
            last_q      <= drain_last;
            if (drain_last) begin
              fill_q  <= '0;
              state_q <= S_IDLE;
            end else begin
              idx_q <= IDX_W'(CNT_W'(idx_q) + CNT_W'(1));
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign out_handle_o = handle_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ===== rtl/dispatch_buffer_broadcast_dedup_unit.sv =====
// Dispatch buffer of DEPTH slots that fills from slot 0 upward, with a duplicate
// filter for broadcasts. An insert request (op 0) returns one result: stored, duplicate
// dropped (slot of the matching entry) or full dropped. A broadcast insert into a
// non-empty buffer reads the stored entries one per cycle through the single read
// port of the entry memory and stops at the first match. A drain request (op 1)
// returns every stored handle in slot order, one per cycle while the output is not
// stalled, with last set on the final one, or a single drain-empty result. Requests
// are taken one at a time; a finished result waits in the output register while the
// next request is accepted.
`default_nettype none

module dispatch_buffer_broadcast_dedup_unit #(
  parameter int unsigned DEPTH      = dbd_pkg::DEPTH_DEF,
  parameter int unsigned ADDR_BYTES = dbd_pkg::ADDR_BYTES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         op_i,
  input  wire logic [dbd_pkg::HANDLE_W-1:0] pkt_handle_i,
  input  wire logic                         is_broadcast_i,
  input  wire logic [dbd_pkg::SEQ_W-1:0]    seq_nr_i,
  input  wire logic [dbd_pkg::LEN_W-1:0]    src_len_i,
  input  wire logic [dbd_pkg::SRC_W-1:0]    ll_addr_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [dbd_pkg::STATUS_W-1:0] status_o,
  output logic      [dbd_pkg::SLOT_W-1:0]   slot_o,
  output logic      [dbd_pkg::HANDLE_W-1:0] out_handle_o,
  output logic                              last_o
);
  import dbd_pkg::*;

  localparam int unsigned ADDR_W = ADDR_BYTES * 8;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  dbd_meta_t         wr_meta;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  dbd_meta_t         rd_meta;
  logic [ADDR_W-1:0] rd_addr;

  dbd_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .IDX_W  (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_meta_i (wr_meta),
    .wr_addr_i (wr_addr),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx),
    .rd_meta_o (rd_meta),
    .rd_addr_o (rd_addr)
  );

  dbd_ctrl #(
    .DEPTH      (DEPTH),
    .ADDR_BYTES (ADDR_BYTES),
    .ADDR_W     (ADDR_W),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .pkt_handle_i   (pkt_handle_i),
    .is_broadcast_i (is_broadcast_i),
    .seq_nr_i       (seq_nr_i),
    .src_len_i      (src_len_i),
    .ll_addr_i      (ll_addr_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .out_handle_o   (out_handle_o),
    .last_o         (last_o),
    .wr_en_o        (wr_en),
    .wr_idx_o       (wr_idx),
    .wr_meta_o      (wr_meta),
    .wr_addr_o      (wr_addr),
    .rd_en_o        (rd_en),
    .rd_idx_o       (rd_idx),
    .rd_meta_i      (rd_meta),
    .rd_addr_i      (rd_addr)
  );

endmodule

`default_nettype wire

// ===== rtl/dbd_checker.sv =====
`default_nettype none

module dbd_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         op_i,
  input wire logic [dbd_pkg::HANDLE_W-1:0] pkt_handle_i,
  input wire logic                         is_broadcast_i,
  input wire logic [dbd_pkg::SEQ_W-1:0]    seq_nr_i,
  input wire logic [dbd_pkg::LEN_W-1:0]    src_len_i,
  input wire logic [dbd_pkg::SRC_W-1:0]    ll_addr_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [dbd_pkg::STATUS_W-1:0] status_o,
  input wire logic [dbd_pkg::SLOT_W-1:0]   slot_o,
  input wire logic [dbd_pkg::HANDLE_W-1:0] out_handle_o,
  input wire logic                         last_o
);
  import dbd_pkg::*;

  // only drained entries may leave last low
  a_nonlast_is_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == ST_DRAINED)
    else $error("non-last result that is not a drained entry");

  // no new request while a drain is still emitting
  a_drain_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("request taken during drain");

  // drain empty result carries zero slot and handle
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> slot_o == '0 && out_handle_o == '0 && last_o)
    else $error("malformed drain empty result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(slot_o) &&
      $stable(out_handle_o) && $stable(last_o))
    else $error("stalled result changed");

endmodule

bind dispatch_buffer_broadcast_dedup_unit dbd_checker u_dbd_checker (.*);

`default_nettype wire
